>>> rtl/t3db_pkg.sv
package t3db_pkg;

  localparam int TOP_K     = 3;
  localparam int COUNT_W   = 16;
  localparam int SCORE_W   = 8;
  localparam int OUT_CNT_W = 16;
  localparam int SHOW_K    = 3;
  localparam int SHOW_W    = 2;
  localparam int NUM_BANDS = 4;
  localparam int FOUND_W   = $clog2(TOP_K + 1);
  localparam int CFG_IDX_W = 2;

  typedef logic [SCORE_W-1:0]   score_t;
  typedef logic [COUNT_W-1:0]   count_t;
  typedef logic [FOUND_W-1:0]   found_t;
  typedef logic [OUT_CNT_W-1:0] out_count_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BAND_A = 2'd0,
    REG_BAND_B = 2'd1,
    REG_BAND_C = 2'd2
  } cfg_reg_t;

  localparam score_t BAND_A_RESET = 8'd90;
  localparam score_t BAND_B_RESET = 8'd75;
  localparam score_t BAND_C_RESET = 8'd60;

  typedef struct packed {
    score_t a_min;
    score_t b_min;
    score_t c_min;
  } band_cfg_t;

  typedef struct packed {
    logic upd;
    logic clr;
  } upd_ctrl_t;

  typedef struct packed {
    score_t [TOP_K-1:0] vals;
    count_t [TOP_K-1:0] cnts;
    found_t             found;
  } top_set_t;

  typedef struct packed {
    count_t [NUM_BANDS-1:0] bands;
    count_t                 total;
  } band_set_t;

  function automatic count_t sat_inc(input count_t v);
    count_t r;
    r = (v == {COUNT_W{1'b1}}) ? v : v + 1'b1;
    return r;
  endfunction

  function automatic out_count_t show_count(input count_t v);
    out_count_t r;
    r = (32'(v) > 32'((1 << OUT_CNT_W) - 1)) ? {OUT_CNT_W{1'b1}} : OUT_CNT_W'(v);
    return r;
  endfunction

endpackage

>>> rtl/t3db_if.sv
interface t3db_score_if;
  import t3db_pkg::*;

  logic   valid;
  logic   ready;
  score_t score;
  logic   last;

  modport source (output valid, output score, output last, input ready);
  modport sink (input valid, input score, input last, output ready);
endinterface

interface t3db_result_if;
  import t3db_pkg::*;

  logic              valid;
  logic              ready;
  score_t            first_value;
  score_t            second_value;
  score_t            third_value;
  out_count_t        first_count;
  out_count_t        second_count;
  out_count_t        third_count;
  logic [SHOW_W-1:0] found;
  out_count_t        band_a_count;
  out_count_t        band_b_count;
  out_count_t        band_c_count;
  out_count_t        band_d_count;
  out_count_t        total;

  modport source (
    output valid, output first_value, output second_value, output third_value,
    output first_count, output second_count, output third_count, output found,
    output band_a_count, output band_b_count, output band_c_count,
    output band_d_count, output total, input ready
  );
  modport sink (
    input valid, input first_value, input second_value, input third_value,
    input first_count, input second_count, input third_count, input found,
    input band_a_count, input band_b_count, input band_c_count,
    input band_d_count, input total, output ready
  );
endinterface

>>> rtl/top3_distinct_and_grade_bins.sv
// Channel  Direction  Word
// scores   in         score, last
// results  out        top three values and counts, found, four band counts, total
// cfg      in         cfg_we, cfg_idx, cfg_data (band_a_min, band_b_min, band_c_min)
//
// An accepted score waits in the input register; when it leaves, the insertion and band logic
// update the run state and, for a last score, the result register.
// A new score can be accepted every cycle while the input is not stalled; the result of a run
// appears on the cycle after its last score leaves the input register. Reset is synchronous and
// restores the default thresholds and an empty run. A waiting result only stalls the input when a
// further last score reaches the update stage.
module top3_distinct_and_grade_bins (
  input  logic                       clk,
  input  logic                       rst,
  t3db_score_if.sink                 scores,
  t3db_result_if.source              results,
  input  logic                       cfg_we,
  input  logic [t3db_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  t3db_pkg::score_t           cfg_data
);
  import t3db_pkg::*;

  band_cfg_t  cfg;
  logic       s1_valid;
  score_t     s1_score;
  logic       s1_last;
  logic       go;
  upd_ctrl_t  ctl;
  top_set_t   ts_after;
  band_set_t  bs_after;
  logic       res_valid;
  score_t     [SHOW_K-1:0] show_vals;
  out_count_t [SHOW_K-1:0] show_cnts;
  score_t     [SHOW_K-1:0] res_vals;
  out_count_t [SHOW_K-1:0] res_cnts;
  logic       [SHOW_W-1:0] res_found;
  out_count_t [NUM_BANDS-1:0] res_bands;
  out_count_t res_total;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.a_min <= BAND_A_RESET;
      cfg.b_min <= BAND_B_RESET;
      cfg.c_min <= BAND_C_RESET;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_BAND_A: cfg.a_min <= cfg_data;
        REG_BAND_B: cfg.b_min <= cfg_data;
        REG_BAND_C: cfg.c_min <= cfg_data;
        default: ;
      endcase
    end
  end

  assign go           = s1_valid && (!s1_last || !res_valid || results.ready);
  assign scores.ready = !s1_valid || go;
  assign ctl.upd      = go;
  assign ctl.clr      = s1_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (scores.valid && scores.ready) begin
      s1_valid <= 1'b1;
    end else if (go) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (scores.valid && scores.ready) begin
      s1_score <= scores.score;
      s1_last  <= scores.last;
    end
  end

  t3db_top_set u_top_set (
    .clk   (clk),
    .rst   (rst),
    .ctl   (ctl),
    .score (s1_score),
    .after (ts_after)
  );

  t3db_band_count u_band_count (
    .clk   (clk),
    .rst   (rst),
    .ctl   (ctl),
    .cfg   (cfg),
    .score (s1_score),
    .after (bs_after)
  );

  always_comb begin
    for (int k = 0; k < SHOW_K; k++) begin
      if (k < TOP_K && FOUND_W'(k) < ts_after.found) begin
        show_vals[k] = ts_after.vals[k];
        show_cnts[k] = show_count(ts_after.cnts[k]);
      end else begin
        show_vals[k] = '0;
        show_cnts[k] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (go && s1_last) begin
      res_valid <= 1'b1;
    end else if (results.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go && s1_last) begin
      res_vals  <= show_vals;
      res_cnts  <= show_cnts;
      res_found <= (32'(ts_after.found) > SHOW_K) ? SHOW_W'(SHOW_K) : SHOW_W'(ts_after.found);
      for (int k = 0; k < NUM_BANDS; k++) begin
        res_bands[k] <= show_count(bs_after.bands[k]);
      end
      res_total <= show_count(bs_after.total);
    end
  end

  assign results.valid        = res_valid;
  assign results.first_value  = res_vals[0];
  assign results.second_value = res_vals[1];
  assign results.third_value  = res_vals[2];
  assign results.first_count  = res_cnts[0];
  assign results.second_count = res_cnts[1];
  assign results.third_count  = res_cnts[2];
  assign results.found        = res_found;
  assign results.band_a_count = res_bands[0];
  assign results.band_b_count = res_bands[1];
  assign results.band_c_count = res_bands[2];
  assign results.band_d_count = res_bands[3];
  assign results.total        = res_total;

`ifndef ASSERT_OFF
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(go && s1_last))
    else $error("result word appeared without a closing score");
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !scores.ready |-> s1_valid && s1_last && res_valid)
    else $error("input stalled with no waiting result");
  a_result_nonempty: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> res_found != '0 && res_total != '0)
    else $error("result word reports an empty run");
`endif

endmodule

>>> rtl/t3db_top_set.sv
module t3db_top_set (
  input  logic                clk,
  input  logic                rst,
  input  t3db_pkg::upd_ctrl_t ctl,
  input  t3db_pkg::score_t    score,
  output t3db_pkg::top_set_t  after
);
  import t3db_pkg::*;

  top_set_t                     st;
  logic [TOP_K-1:0]             hit;
  logic [TOP_K-1:0]             gt;
  logic [TOP_K-1:0]             prev_gt;
  logic [TOP_K-1:0][SCORE_W-1:0] vals_sh;
  logic [TOP_K-1:0][COUNT_W-1:0] cnts_sh;

  always_comb begin
    for (int i = 0; i < TOP_K; i++) begin
      hit[i] = (FOUND_W'(i) < st.found) && (st.vals[i] == score);
      gt[i]  = (FOUND_W'(i) < st.found) && (st.vals[i] > score);
    end
    prev_gt = gt << 1;
    vals_sh = st.vals << SCORE_W;
    cnts_sh = st.cnts << COUNT_W;
    after   = st;
    if (|hit) begin
      for (int i = 0; i < TOP_K; i++) begin
        if (hit[i]) begin
          after.cnts[i] = sat_inc(st.cnts[i]);
        end
      end
    end else begin
      for (int i = 0; i < TOP_K; i++) begin
        if (!gt[i]) begin
          if (!prev_gt[i] && i != 0) begin
            after.vals[i] = vals_sh[i];
            after.cnts[i] = cnts_sh[i];
          end else begin
            after.vals[i] = score;
            after.cnts[i] = COUNT_W'(1);
          end
        end
      end
      if (st.found != FOUND_W'(TOP_K)) begin
        after.found = st.found + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (ctl.upd) begin
      st <= ctl.clr ? '0 : after;
    end
  end

`ifndef ASSERT_OFF
  a_found_bound: assert property (@(posedge clk) disable iff (rst)
    32'(st.found) <= TOP_K)
    else $error("top set holds more entries than it has room for");
  a_found_hold: assert property (@(posedge clk) disable iff (rst)
    !ctl.upd |=> $stable(st.found))
    else $error("top set fill changed without an update");
`endif

endmodule

>>> rtl/t3db_band_count.sv
module t3db_band_count (
  input  logic                clk,
  input  logic                rst,
  input  t3db_pkg::upd_ctrl_t ctl,
  input  t3db_pkg::band_cfg_t cfg,
  input  t3db_pkg::score_t    score,
  output t3db_pkg::band_set_t after
);
  import t3db_pkg::*;

  band_set_t              st;
  logic [NUM_BANDS-1:0]   sel;

  always_comb begin
    sel = '0;
    priority if (score >= cfg.a_min) begin
      sel[0] = 1'b1;
    end else if (score >= cfg.b_min) begin
      sel[1] = 1'b1;
    end else if (score >= cfg.c_min) begin
      sel[2] = 1'b1;
    end else begin
      sel[3] = 1'b1;
    end
    after = st;
    for (int k = 0; k < NUM_BANDS; k++) begin
      if (sel[k]) begin
        after.bands[k] = sat_inc(st.bands[k]);
      end
    end
    after.total = sat_inc(st.total);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (ctl.upd) begin
      st <= ctl.clr ? '0 : after;
    end
  end

`ifndef ASSERT_OFF
  a_clear_total: assert property (@(posedge clk) disable iff (rst)
    ctl.upd && ctl.clr |=> st.total == '0)
    else $error("run total not cleared at the end of a run");
`endif

endmodule
